[hdl/mbq_pkg.sv]
// Shared types, widths, register indexes and the microcode table of the
// multichannel biquad filter. No dependencies.
`default_nettype none

package mbq_pkg;

    // Field and datapath widths
    localparam int SampleW   = 16;
    localparam int ChanW     = 3;
    localparam int CoefW     = 24;
    localparam int CfgIdxW   = 3;
    localparam int StateW    = 40;
    localparam int AccW      = 48;   // y, n1 and n2 stay well inside 45 bits
    localparam int YrW       = 22;   // rounded output before saturation
    localparam int ProdW     = CoefW + YrW;
    localparam int RndShift  = 20;
    localparam int StepW     = 4;

    localparam int MBQ_CHANNELS = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_FEED_COEF_0 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FEED_COEF_1 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_FEED_COEF_2 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BACK_COEF_1 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BACK_COEF_2 = 3'd4;

    // Coefficient selects for the multiplier
    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    // Wait conditions: the step repeats while the condition holds
    localparam logic [1:0] WAIT_NONE = 2'd0;
    localparam logic [1:0] WAIT_IN   = 2'd1;
    localparam logic [1:0] WAIT_OUT  = 2'd2;

    // Accumulator operations
    localparam logic [2:0] ACC_HOLD    = 3'd0;
    localparam logic [2:0] ACC_P_Z1    = 3'd1;
    localparam logic [2:0] ACC_P_Z2    = 3'd2;
    localparam logic [2:0] ACC_SUB_P   = 3'd3;
    localparam logic [2:0] ACC_LOAD_P  = 3'd4;

    // Step numbers of the program
    localparam logic [StepW-1:0] ST_IDLE  = 4'd0;
    localparam logic [StepW-1:0] ST_M_B0  = 4'd1;
    localparam logic [StepW-1:0] ST_Y     = 4'd2;
    localparam logic [StepW-1:0] ST_RND   = 4'd3;
    localparam logic [StepW-1:0] ST_N1A   = 4'd4;
    localparam logic [StepW-1:0] ST_N1B   = 4'd5;
    localparam logic [StepW-1:0] ST_N1C   = 4'd6;
    localparam logic [StepW-1:0] ST_N2    = 4'd7;
    localparam logic [StepW-1:0] ST_DONE  = 4'd8;

    typedef struct packed {
        logic [1:0]       wait_cond;
        logic [StepW-1:0] nxt;
        logic             take_in;   // accept an item, latch sample and delays
        logic             mul_en;
        logic [2:0]       coef_sel;
        logic             mul_y;     // second operand: rounded y, else sample
        logic [2:0]       acc_op;
        logic             cap_y;     // round y, start overflow flag
        logic             cap_n1;    // keep n1, check it
        logic             fin;       // check n2, write back, load output
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } t_stat;

    function automatic t_ctrl mbq_ucode(input logic [StepW-1:0] step);
        t_ctrl w;
        w = '0;
        w.wait_cond = WAIT_NONE;
        w.acc_op    = ACC_HOLD;
        w.coef_sel  = COEF_B0;
        unique case (step)
            ST_IDLE: begin
                w.wait_cond = WAIT_IN;
                w.take_in   = 1'b1;
                w.nxt       = ST_M_B0;
            end
            ST_M_B0: begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B0;
                w.nxt      = ST_Y;
            end
            ST_Y: begin
                w.acc_op = ACC_P_Z1;
                w.nxt    = ST_RND;
            end
            ST_RND: begin
                w.cap_y    = 1'b1;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B1;
                w.nxt      = ST_N1A;
            end
            ST_N1A: begin
                w.acc_op   = ACC_P_Z2;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A1;
                w.mul_y    = 1'b1;
                w.nxt      = ST_N1B;
            end
            ST_N1B: begin
                w.acc_op   = ACC_SUB_P;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B2;
                w.nxt      = ST_N1C;
            end
            ST_N1C: begin
                w.cap_n1   = 1'b1;
                w.acc_op   = ACC_LOAD_P;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A2;
                w.mul_y    = 1'b1;
                w.nxt      = ST_N2;
            end
            ST_N2: begin
                w.acc_op = ACC_SUB_P;
                w.nxt    = ST_DONE;
            end
            ST_DONE: begin
                w.wait_cond = WAIT_OUT;
                w.fin       = 1'b1;
                w.nxt       = ST_IDLE;
            end
            default: begin
                w.nxt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/multichannel_biquad_filter.sv]
// Top level of the multichannel biquad filter: coefficient registers, stream
// ports, sequencer and datapath. Depends on mbq_pkg, mbq_sequencer, mbq_datapath.
`default_nettype none

// Second-order IIR filter, transposed direct form II, one shared set of five
// Q3.20 coefficients and a separate pair of 40-bit delays per channel.
// Each item is a Q1.15 sample with its channel; each gives exactly one result
// item: the filtered sample rounded half up and saturated to Q1.15, the
// channel echoed, and a flag that is set when y or a new delay value left the
// 40-bit range. In that case both delays of the channel are cleared and the
// sample is 0. A channel at or above CHANNELS is filtered from zero delays and
// its state is left alone. A small microcode program runs the five products of
// each item through a single 24x22 multiplier, one product per step, with an
// accumulator behind it, and then returns to its wait step.
// The input is taken only in the program's first step, so items are handled one
// at a time; a result waiting in the output register does not block the next
// item, only the write of the one after it. Coefficients may be written only
// while no item is in flight.
module multichannel_biquad_filter #(
    parameter int CHANNELS = mbq_pkg::MBQ_CHANNELS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // coefficient write port
    input  wire                              i_cfg_we,
    input  wire  [mbq_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  wire  [mbq_pkg::CoefW-1:0]        i_cfg_data,
    // input stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [15:0]                      s_axis_tdata,  // [15:0] sample_in
    input  wire  [7:0]                       s_axis_tuser,  // [2:0] channel_in
    // result stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [15:0]                      m_axis_tdata,  // [15:0] sample_out
    output logic [7:0]                       m_axis_tuser   // [2:0] channel_out,
                                                            // [3] state_cleared
);
    import mbq_pkg::*;

    logic signed [CoefW-1:0] r_b0;
    logic signed [CoefW-1:0] r_b1;
    logic signed [CoefW-1:0] r_b2;
    logic signed [CoefW-1:0] r_a1;
    logic signed [CoefW-1:0] r_a2;

    t_ctrl ctrl;
    t_stat stat;
    t_stat dp_stat;

    logic signed [SampleW-1:0] out_sample;
    logic        [ChanW-1:0]   out_chan;
    logic                      out_cleared;

    // Coefficient registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= 24'sd1048576;   // unity gain
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FEED_COEF_0: r_b0 <= i_cfg_data;
                REG_FEED_COEF_1: r_b1 <= i_cfg_data;
                REG_FEED_COEF_2: r_b2 <= i_cfg_data;
                REG_BACK_COEF_1: r_a1 <= i_cfg_data;
                REG_BACK_COEF_2: r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign stat.in_valid = s_axis_tvalid;
    assign stat.out_busy = dp_stat.out_busy;

    mbq_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_ctrl  (ctrl)
    );

    mbq_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_b0        (r_b0),
        .i_b1        (r_b1),
        .i_b2        (r_b2),
        .i_a1        (r_a1),
        .i_a2        (r_a2),
        .i_sample    (s_axis_tdata[SampleW-1:0]),
        .i_chan      (s_axis_tuser[ChanW-1:0]),
        .i_out_ready (m_axis_tready),
        .o_stat_out  (dp_stat),
        .o_out_valid (m_axis_tvalid),
        .o_sample    (out_sample),
        .o_chan      (out_chan),
        .o_cleared   (out_cleared)
    );

    assign m_axis_tdata = out_sample;
    assign m_axis_tuser = {4'b0000, out_cleared, out_chan};

endmodule

`default_nettype wire

[hdl/mbq_sequencer.sv]
// Step counter and microcode fetch for the multichannel biquad filter.
// Depends on mbq_pkg (control word, microcode table).
`default_nettype none

module mbq_sequencer (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  mbq_pkg::t_stat  i_stat,
    output logic            o_ready,
    output mbq_pkg::t_ctrl  o_ctrl
);
    import mbq_pkg::*;

    logic [StepW-1:0] r_step;
    logic [StepW-1:0] n_step;
    t_ctrl            word;
    logic             hold;

    assign word = mbq_ucode(r_step);

    always_comb begin
        unique case (word.wait_cond)
            WAIT_IN:  hold = !i_stat.in_valid;
            WAIT_OUT: hold = i_stat.out_busy;
            default:  hold = 1'b0;
        endcase
    end

    assign n_step  = hold ? r_step : word.nxt;
    assign o_ready = word.take_in;

    // Side-effecting actions only fire on the cycle the step moves on
    always_comb begin
        o_ctrl         = word;
        o_ctrl.take_in = word.take_in & ~hold;
        o_ctrl.fin     = word.fin & ~hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

[hdl/mbq_datapath.sv]
// Shared multiplier, accumulator, per-channel delay store and output register
// of the multichannel biquad filter. Depends on mbq_pkg.
`default_nettype none

module mbq_datapath #(
    parameter int CHANNELS = mbq_pkg::MBQ_CHANNELS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  mbq_pkg::t_ctrl                      i_ctrl,
    input  wire signed [mbq_pkg::CoefW-1:0]     i_b0,
    input  wire signed [mbq_pkg::CoefW-1:0]     i_b1,
    input  wire signed [mbq_pkg::CoefW-1:0]     i_b2,
    input  wire signed [mbq_pkg::CoefW-1:0]     i_a1,
    input  wire signed [mbq_pkg::CoefW-1:0]     i_a2,
    input  wire signed [mbq_pkg::SampleW-1:0]   i_sample,
    input  wire        [mbq_pkg::ChanW-1:0]     i_chan,
    input  wire                                 i_out_ready,
    output mbq_pkg::t_stat                      o_stat_out,
    output logic                                o_out_valid,
    output logic signed [mbq_pkg::SampleW-1:0]  o_sample,
    output logic        [mbq_pkg::ChanW-1:0]    o_chan,
    output logic                                o_cleared
);
    import mbq_pkg::*;

    localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [ChanW:0] ChanLimit = (ChanW+1)'(CHANNELS);

    // Delay store: one z1 and z2 per channel
    logic signed [StateW-1:0] r_z1_mem [CHANNELS];
    logic signed [StateW-1:0] r_z2_mem [CHANNELS];

    logic signed [SampleW-1:0] r_x;
    logic        [ChanW-1:0]   r_ch;
    logic                      r_ch_ok;
    logic signed [StateW-1:0]  r_z1;
    logic signed [StateW-1:0]  r_z2;
    logic signed [ProdW-1:0]   r_p;
    logic signed [AccW-1:0]    r_acc;
    logic signed [AccW-1:0]    n_acc;
    logic signed [YrW-1:0]     r_yr;
    logic signed [StateW-1:0]  r_n1;
    logic                      r_ovf;

    logic                      in_ok;
    logic [IdxW-1:0]           in_idx;
    logic [IdxW-1:0]           wr_idx;
    logic signed [CoefW-1:0]   mul_a;
    logic signed [YrW-1:0]     mul_b;
    logic signed [AccW-1:0]    p_ext;
    logic signed [AccW-1:0]    rnd_sum;
    logic                      acc_fits;
    logic                      ovf_final;
    logic signed [SampleW-1:0] sat_y;

    logic                      r_out_valid;
    logic signed [SampleW-1:0] r_out_sample;
    logic        [ChanW-1:0]   r_out_chan;
    logic                      r_out_cleared;

    assign in_ok  = ({1'b0, i_chan} < ChanLimit);
    assign in_idx = i_chan[IdxW-1:0];
    assign wr_idx = r_ch[IdxW-1:0];

    // Item capture and delay read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take_in) begin
            r_x     <= i_sample;
            r_ch    <= i_chan;
            r_ch_ok <= in_ok;
            r_z1    <= in_ok ? r_z1_mem[in_idx] : '0;
            r_z2    <= in_ok ? r_z2_mem[in_idx] : '0;
        end
    end

    // Shared multiplier with registered product
    always_comb begin
        unique case (i_ctrl.coef_sel)
            COEF_B0: mul_a = i_b0;
            COEF_B1: mul_a = i_b1;
            COEF_B2: mul_a = i_b2;
            COEF_A1: mul_a = i_a1;
            COEF_A2: mul_a = i_a2;
            default: mul_a = i_b0;
        endcase
    end

    assign mul_b = i_ctrl.mul_y ? r_yr : YrW'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_p <= mul_a * mul_b;
        end
    end

    assign p_ext = AccW'(r_p);

    always_comb begin
        unique case (i_ctrl.acc_op)
            ACC_P_Z1:   n_acc = p_ext + AccW'(r_z1);
            ACC_P_Z2:   n_acc = p_ext + AccW'(r_z2);
            ACC_SUB_P:  n_acc = r_acc - p_ext;
            ACC_LOAD_P: n_acc = p_ext;
            default:    n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Accumulator fits 40 bits when its top bits are all sign copies
    assign acc_fits = (r_acc[AccW-1:StateW-1] == '0) || (r_acc[AccW-1:StateW-1] == '1);
    assign rnd_sum  = r_acc + (AccW'(1) <<< (RndShift - 1));
    assign ovf_final = r_ovf | ~acc_fits;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap_y) begin
            r_yr  <= rnd_sum[RndShift+YrW-1:RndShift];
            r_ovf <= ~acc_fits;
        end else if (i_ctrl.cap_n1) begin
            r_n1  <= r_acc[StateW-1:0];
            r_ovf <= ovf_final;
        end
    end

    // Saturate rounded y to Q1.15
    always_comb begin
        if (r_yr > YrW'(32767)) begin
            sat_y = 16'sh7FFF;
        end else if (r_yr < -YrW'(32768)) begin
            sat_y = -16'sh8000;
        end else begin
            sat_y = r_yr[SampleW-1:0];
        end
    end

    // Write-back: overflow clears the channel; all delays start at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_z1_mem[c] <= '0;
                r_z2_mem[c] <= '0;
            end
        end else if (i_ctrl.fin && r_ch_ok) begin
            r_z1_mem[wr_idx] <= ovf_final ? '0 : r_n1;
            r_z2_mem[wr_idx] <= ovf_final ? '0 : r_acc[StateW-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fin) begin
            r_out_sample  <= ovf_final ? '0 : sat_y;
            r_out_chan    <= r_ch;
            r_out_cleared <= ovf_final;
        end
    end

    assign o_stat_out.in_valid = 1'b0;
    assign o_stat_out.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_chan      = r_out_chan;
    assign o_cleared   = r_out_cleared;

endmodule

`default_nettype wire

[bench/multichannel_biquad_filter_tb.sv]
// Self-checking bench for multichannel_biquad_filter: stream driver, result
// monitor and a cycle-free predictor of the biquad with its own per-channel state.
// Depends on mbq_pkg and the multichannel_biquad_filter RTL.

module multichannel_biquad_filter_tb;

    import mbq_pkg::*;

    localparam int     CHAN_CNT     = MBQ_CHANNELS;
    localparam int     STUCK_LIMIT  = 2000;   // cycles with no item moving
    localparam int     HOLD_LEN     = 300;    // long receiver hold-off
    localparam int     SETTLE       = 12;     // > item latency
    localparam int     PHASE_ITEMS  = 125;
    localparam int     RAND_PHASES  = 8;
    localparam int     COEF_MAX     = 8388607;
    localparam int     COEF_MIN     = -8388608;
    localparam int     COEF_ONE     = 1048576;   // 1.0 in Q3.20
    localparam longint ACC_TOP      = 64'sh7F_FFFF_FFFF;
    localparam longint ACC_BOT      = -ACC_TOP - 1;
    localparam longint ROUND_HALF   = 64'sd524288;
    localparam logic [CfgIdxW-1:0] REG_SPARE_LO = REG_BACK_COEF_2 + 3'd1;

    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic [ChanW-1:0]          chan;
    } t_audio_item;

    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic [ChanW-1:0]   chan;
        logic               cleared;
    } t_filtered_item;

    // DUT inputs, all known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_idx     = '0;
    logic [CoefW-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [15:0]          s_axis_tdata  = '0;
    logic [7:0]           s_axis_tuser  = '0;
    logic                 m_axis_tready = 1'b0;

    // DUT outputs
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [15:0]          m_axis_tdata;
    logic [7:0]           m_axis_tuser;

    // Predictor copy of the coefficients and delay lines
    logic signed [CoefW-1:0]  coef_b0 = CoefW'(COEF_ONE);
    logic signed [CoefW-1:0]  coef_b1 = '0;
    logic signed [CoefW-1:0]  coef_b2 = '0;
    logic signed [CoefW-1:0]  coef_a1 = '0;
    logic signed [CoefW-1:0]  coef_a2 = '0;
    logic signed [StateW-1:0] delay_z1 [CHAN_CNT];
    logic signed [StateW-1:0] delay_z2 [CHAN_CNT];

    t_audio_item    pending_samples [$];
    t_filtered_item awaited_outputs [$];
    t_audio_item    next_item;

    int   mismatch_count = 0;
    int   send_wait      = 0;
    int   recv_wait      = 0;
    int   recv_next;
    int   hold_requests  = 0;
    int   holds_served   = 0;
    int   stuck_cycles   = 0;
    bit   send_idle      = 1'b0;
    bit   recv_idle      = 1'b0;

    multichannel_biquad_filter #(
        .CHANNELS (CHAN_CNT)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        for (int c = 0; c < CHAN_CNT; c++) begin
            delay_z1[c] = '0;
            delay_z2[c] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: one biquad step in TDF-II, 64-bit arithmetic so that the
    // 40-bit overflow guard can be judged exactly.
    //   y  = b0*x + z1,  yr = floor((y + 2^19) / 2^20)
    //   z1 = b1*x - a1*yr + z2,  z2 = b2*x - a2*yr
    // ------------------------------------------------------------------
    task automatic biquad_step(input logic signed [SampleW-1:0] x_in,
                               input logic [ChanW-1:0] ch);
        longint         x, z1, z2, y, yr, n1, n2, o;
        longint         b0, b1, b2, a1, a2;
        bit             in_range, cleared;
        t_filtered_item r;
        x  = x_in;
        b0 = coef_b0;
        b1 = coef_b1;
        b2 = coef_b2;
        a1 = coef_a1;
        a2 = coef_a2;
        in_range = ch < CHAN_CNT;
        z1 = 0;
        z2 = 0;
        // channels beyond the configured count run from zero delays
        if (in_range) begin
            z1 = delay_z1[ch];
            z2 = delay_z2[ch];
        end
        y  = b0 * x + z1;
        yr = (y + ROUND_HALF) >>> RndShift;   // arithmetic shift = floor
        n1 = b1 * x - a1 * yr + z2;
        n2 = b2 * x - a2 * yr;
        cleared = y  < ACC_BOT || y  > ACC_TOP ||
                  n1 < ACC_BOT || n1 > ACC_TOP ||
                  n2 < ACC_BOT || n2 > ACC_TOP;
        if (cleared) begin
            // overflow guard: wipe the channel and mute the sample
            n1 = 0;
            n2 = 0;
            o  = 0;
        end else begin
            o = yr;
            if (o > 32767)  o = 32767;
            if (o < -32768) o = -32768;
        end
        if (in_range) begin
            delay_z1[ch] = n1[StateW-1:0];
            delay_z2[ch] = n2[StateW-1:0];
        end
        r.sample  = o[SampleW-1:0];
        r.chan    = ch;
        r.cleared = cleared;
        awaited_outputs.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        // keep the log bounded on a badly broken build; every one is counted
        if (mismatch_count < 100)
            $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: drains the pending queue; a random pause is drawn per item
    // while send_idle is set and applied after the item has gone.  tvalid stays up
    // back to back when the pause is zero, with a single NBA per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_wait     <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                biquad_step(s_axis_tdata, s_axis_tuser[ChanW-1:0]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait != 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_wait     <= send_wait - 1;
                end else if (pending_samples.size() != 0) begin
                    next_item      = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.sample;
                    s_axis_tuser  <= {5'b0, next_item.chan};
                    send_wait     <= send_idle ? int'($urandom_range(0, 16)) : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each result against the oldest expectation, then
    // drops tready for a random pause if recv_idle is set.  A hold request from the
    // stimulus process turns into a long hold-off counted here.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
        end else begin
            recv_next = recv_wait;
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_outputs.size() == 0) begin
                    report_mismatch("result with nothing expected", m_axis_tdata, 0);
                end else begin
                    t_filtered_item want;
                    want = awaited_outputs.pop_front();
                    if (m_axis_tdata != want.sample)
                        report_mismatch("sample_out", $signed(m_axis_tdata),
                                        $signed(want.sample));
                    if (m_axis_tuser[ChanW-1:0] != want.chan)
                        report_mismatch("channel_out", m_axis_tuser[ChanW-1:0], want.chan);
                    if (m_axis_tuser[ChanW] != want.cleared)
                        report_mismatch("state_cleared", m_axis_tuser[ChanW], want.cleared);
                end
                recv_next = recv_idle ? int'($urandom_range(0, 16)) : 0;
            end
            if (hold_requests != holds_served) begin
                holds_served <= holds_served + 1;
                recv_next     = HOLD_LEN;
            end
            if (recv_next != 0) begin
                m_axis_tready <= 1'b0;
                recv_wait     <= recv_next - 1;
            end else begin
                m_axis_tready <= 1'b1;
                recv_wait     <= 0;
            end
        end
    end

    // Watchdog: any item moving or a register write counts as progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_we || !i_rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STUCK_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_coef(input logic [CfgIdxW-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CoefW-1:0];
        // no item in flight, so the predictor copy may change right away
        case (idx)
            REG_FEED_COEF_0: coef_b0 = value[CoefW-1:0];
            REG_FEED_COEF_1: coef_b1 = value[CoefW-1:0];
            REG_FEED_COEF_2: coef_b2 = value[CoefW-1:0];
            REG_BACK_COEF_1: coef_a1 = value[CoefW-1:0];
            REG_BACK_COEF_2: coef_a2 = value[CoefW-1:0];
            default: ;   // spare index, write has no effect
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_coefs(input int b0, input int b1, input int b2,
                             input int a1, input int a2);
        write_coef(REG_FEED_COEF_0, b0);
        write_coef(REG_FEED_COEF_1, b1);
        write_coef(REG_FEED_COEF_2, b2);
        write_coef(REG_BACK_COEF_1, a1);
        write_coef(REG_BACK_COEF_2, a2);
    endtask

    task automatic queue_item(input int sample, input int chan);
        t_audio_item it;
        it.sample = sample[SampleW-1:0];
        it.chan   = chan[ChanW-1:0];
        pending_samples.push_back(it);
    endtask

    // Wait for every expected result, then let the sequencer settle
    task automatic drain();
        while (pending_samples.size() != 0 || s_axis_tvalid || awaited_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int rand_coef_extreme();
        case ($urandom_range(0, 4))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return 0;
            3:       return COEF_ONE;
            default: return -COEF_ONE;
        endcase
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: case ($urandom_range(0, 4))
                   0:       return 32767;
                   1:       return -32768;
                   2:       return 0;
                   3:       return -1;
                   default: return 1;
               endcase
            1:       return rand_between(-256, 256);
            default: return rand_between(-32768, 32767);
        endcase
    endfunction

    // mostly live channels, some beyond CHANNELS
    function automatic int rand_chan();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 7);
        return $urandom_range(0, CHAN_CNT - 1);
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int b0, b1, b2, a1, a2, lim;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: pass-through, extremes, out-of-range channels
        @(negedge i_clk);
        queue_item(32767, 0);
        queue_item(-32768, 1);
        queue_item(0, 0);
        queue_item(-1, 1);
        queue_item(1, 0);
        queue_item(12345, 7);
        queue_item(-32768, CHAN_CNT);
        drain();

        // All coefficients at their limits: full-scale samples overflow and clear;
        // spare indexes written with junk must change nothing
        set_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        for (int k = 0; k < 3; k++)
            write_coef(REG_SPARE_LO + k[CfgIdxW-1:0], int'($urandom));
        @(negedge i_clk);
        queue_item(32767, 0);
        queue_item(-32768, 1);
        queue_item(1, 0);
        queue_item(0, 1);
        queue_item(-1, 7);
        drain();

        // Gain of 4 with feedback: saturation both ways, live delays
        set_coefs(4 * COEF_ONE, COEF_ONE, 0, COEF_ONE / 2, 0);
        @(negedge i_clk);
        queue_item(32767, 0);
        queue_item(-32768, 1);
        queue_item(-8192, 0);
        queue_item(1000, 1);
        queue_item(0, 0);
        drain();

        // Gain of one half: rounding of exact halves goes up
        set_coefs(COEF_ONE / 2, 0, 0, 0, 0);
        @(negedge i_clk);
        queue_item(1, 0);
        queue_item(-1, 1);
        queue_item(3, 0);
        queue_item(-3, 1);
        drain();

        // Random phases: full-range, stable and extreme coefficient sets,
        // with every mix of idling on the two sides
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 3)
                0: begin
                    b0 = rand_between(COEF_MIN, COEF_MAX);
                    b1 = rand_between(COEF_MIN, COEF_MAX);
                    b2 = rand_between(COEF_MIN, COEF_MAX);
                    a1 = rand_between(COEF_MIN, COEF_MAX);
                    a2 = rand_between(COEF_MIN, COEF_MAX);
                end
                1: begin
                    // inside the stability triangle |a1| < 1 + a2, |a2| < 1
                    a2  = rand_between(-900000, 900000);
                    lim = COEF_ONE + a2 - 50000;
                    a1  = rand_between(-lim, lim);
                    b0  = rand_between(-2 * COEF_ONE, 2 * COEF_ONE);
                    b1  = rand_between(-2 * COEF_ONE, 2 * COEF_ONE);
                    b2  = rand_between(-2 * COEF_ONE, 2 * COEF_ONE);
                end
                default: begin
                    b0 = rand_coef_extreme();
                    b1 = rand_coef_extreme();
                    b2 = rand_coef_extreme();
                    a1 = rand_coef_extreme();
                    a2 = rand_coef_extreme();
                end
            endcase
            set_coefs(b0, b1, b2, a1, a2);
            if ($urandom_range(0, 1) == 1)
                write_coef(REG_SPARE_LO + 3'($urandom_range(0, 2)), int'($urandom));
            @(negedge i_clk);
            send_idle = (ph % 2) == 1;
            recv_idle = (ph % 4) >= 2;
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_item(rand_sample(), rand_chan());
            // receiver stalls for a long stretch while the sender keeps offering
            if ((ph % 4) == 2) begin
                @(posedge i_clk);
                hold_requests <= hold_requests + 1;
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
